FILE: hw/rtl/aabb_pkg.sv
// Shared types and constants for the box table collision and sight unit.
`default_nettype none
package aabb_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_COLL  = 2'd1;
	localparam logic [1:0] OP_SIGHT = 2'd2;

	localparam logic [1:0] CFG_COUNT = 2'd0;
	localparam logic [1:0] CFG_DEAD  = 2'd1;

	// which pair of fractions the compare unit works on
	localparam logic [1:0] SEL_LO  = 2'd0;  // slab entry vs tmin
	localparam logic [1:0] SEL_HI  = 2'd1;  // slab exit vs tmax
	localparam logic [1:0] SEL_FIN = 2'd2;  // tmin vs tmax

	localparam int BODY_HALF   = 13107;   // 0.2 in Q16.16
	localparam int DIR_EPS     = 6;       // |d| must exceed this
	localparam int VIEW_MARGIN = 65536;   // 1.0 in Q16.16
	localparam logic [7:0] SKIP_KIND = 8'd4;

	typedef struct packed {
		logic       load;
		logic       rd;
		logic       clr_idx;
		logic       inc_idx;
		logic       init_t;
		logic       lat_axis;
		logic       mul;
		logic       cmp;
		logic       finish;
		logic       fin_ans;
		logic [1:0] axis;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       dead;
		logic       none;
		logic       last;
		logic       kind_skip;
		logic       pref_fail;
		logic       coll_hit;
		logic       ax_active;
		logic       ax_skip;
		logic       blocked;
	} sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/aabb_ctrl.sv
// Sequencer for box walks, slab steps and result issue.
`default_nettype none
module aabb_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  aabb_pkg::sts_t    sts,
	output aabb_pkg::cmd_t    cmd
);
	import aabb_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_AXS  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_CMP  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] ax_q, ax_d;
	logic [1:0] ph_q, ph_d;
	logic       go_next;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.axis = ax_q;
		cmd.sel  = ph_q;
		state_d  = state_q;
		ax_d     = ax_q;
		ph_d     = ph_q;
		go_next  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) state_d = S_DISP;
			end
			S_DISP: begin
				cmd.clr_idx = 1'b1;
				case (sts.op)
					OP_COLL: begin
						if (sts.dead || sts.none) begin
							cmd.finish  = 1'b1;
							cmd.fin_ans = sts.dead;
							state_d     = S_IDLE;
						end else begin
							state_d = S_RD;
						end
					end
					OP_SIGHT: begin
						if (sts.none) begin
							cmd.finish  = 1'b1;
							cmd.fin_ans = 1'b1;
							state_d     = S_IDLE;
						end else begin
							state_d = S_RD;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.op == OP_COLL) begin
					if (!sts.kind_skip && sts.coll_hit) begin
						cmd.finish  = 1'b1;
						cmd.fin_ans = 1'b1;
						state_d     = S_IDLE;
					end else begin
						go_next = 1'b1;
					end
				end else if (sts.kind_skip || sts.pref_fail) begin
					go_next = 1'b1;
				end else begin
					cmd.init_t = 1'b1;
					ax_d       = 2'd0;
					state_d    = S_AXS;
				end
			end
			S_AXS: begin
				if (sts.ax_skip) begin
					go_next = 1'b1;
				end else if (sts.ax_active) begin
					cmd.lat_axis = 1'b1;
					ph_d         = SEL_LO;
					state_d      = S_MUL;
				end else if (ax_q == 2'd2) begin
					ph_d    = SEL_FIN;
					state_d = S_MUL;
				end else begin
					ax_d = ax_q + 2'd1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				case (ph_q)
					SEL_LO: begin
						ph_d    = SEL_HI;
						state_d = S_MUL;
					end
					SEL_HI: begin
						if (ax_q == 2'd2) begin
							ph_d    = SEL_FIN;
							state_d = S_MUL;
						end else begin
							ax_d    = ax_q + 2'd1;
							state_d = S_AXS;
						end
					end
					default: begin
						if (sts.blocked) begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end else begin
							go_next = 1'b1;
						end
					end
				endcase
			end
			default: state_d = S_IDLE;
		endcase
		if (go_next) begin
			if (sts.last) begin
				cmd.finish  = 1'b1;
				cmd.fin_ans = (sts.op == OP_SIGHT);
				state_d     = S_IDLE;
			end else begin
				cmd.inc_idx = 1'b1;
				state_d     = S_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ax_q    <= 2'd0;
			ph_q    <= SEL_LO;
		end else begin
			state_q <= state_d;
			ax_q    <= ax_d;
			ph_q    <= ph_d;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/aabb_dpath.sv
// Box table, query registers, overlap tests and fraction compare unit.
`default_nettype none
module aabb_dpath #(
	parameter int MAX_BOXES  = 256,
	parameter int COORD_BITS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  aabb_pkg::cmd_t     cmd,
	output aabb_pkg::sts_t     sts,
	input  wire                cfg_valid,
	input  wire  [1:0]         cfg_index,
	input  wire  [8:0]         cfg_data,
	input  wire  [1:0]         op,
	input  wire  [7:0]         entry_index,
	input  wire  [7:0]         entry_kind,
	input  wire  signed [31:0] pos_a_x,
	input  wire  signed [31:0] pos_a_y,
	input  wire  signed [31:0] pos_a_z,
	input  wire  signed [31:0] pos_b_x,
	input  wire  signed [31:0] pos_b_y,
	input  wire  signed [31:0] pos_b_z,
	input  wire  [30:0]        body_height,
	output logic               done,
	output logic               answer,
	output logic [1:0]         answered_op
);
	import aabb_pkg::*;

	localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int NW   = CW + 1;             // slab numerator
	localparam int PW   = 2 * NW;             // cross product
	localparam int EW   = 8 + 6 * CW;         // table entry
	localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNTW = $clog2(MAX_BOXES + 1);
	localparam int XW   = 34;                 // wide signed compare width

	// configuration
	logic [8:0] count_q;
	logic       dead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 9'd0;
			dead_q  <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_COUNT) count_q <= cfg_data;
			if (cfg_index == CFG_DEAD)  dead_q  <= cfg_data[0];
		end
	end

	logic [CNTW-1:0] n_sat;
	assign n_sat = (32'(count_q) > 32'(MAX_BOXES)) ? CNTW'(MAX_BOXES) : CNTW'(count_q);

	// table
	logic [EW-1:0] mem [MAX_BOXES];
	logic [EW-1:0] rd_q;
	logic [CNTW-1:0] idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load && op == OP_WRITE && 32'(entry_index) < 32'(MAX_BOXES))
			mem[IW'(entry_index)] <= {entry_kind,
				pos_b_z[CW-1:0], pos_b_y[CW-1:0], pos_b_x[CW-1:0],
				pos_a_z[CW-1:0], pos_a_y[CW-1:0], pos_a_x[CW-1:0]};
		if (cmd.rd) rd_q <= mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           idx_q <= '0;
		else if (cmd.clr_idx)  idx_q <= '0;
		else if (cmd.inc_idx)  idx_q <= idx_q + 1'b1;
	end

	// query
	logic [1:0]          op_q;
	logic signed [CW-1:0] a_q [3];
	logic signed [CW-1:0] b_q [3];
	logic [30:0]         h_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			a_q[0] <= pos_a_x[CW-1:0];
			a_q[1] <= pos_a_y[CW-1:0];
			a_q[2] <= pos_a_z[CW-1:0];
			b_q[0] <= pos_b_x[CW-1:0];
			b_q[1] <= pos_b_y[CW-1:0];
			b_q[2] <= pos_b_z[CW-1:0];
			h_q    <= body_height;
		end
	end

	logic signed [CW-1:0] lo [3];
	logic signed [CW-1:0] hi [3];
	logic [7:0]           kind;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo[k] = rd_q[k*CW +: CW];
			hi[k] = rd_q[(3+k)*CW +: CW];
		end
		kind = rd_q[6*CW +: 8];
	end

	// collision overlap
	logic signed [XW-1:0] px, py, pz, yh;
	assign px = XW'(a_q[0]);
	assign py = XW'(a_q[1]);
	assign pz = XW'(a_q[2]);
	assign yh = py + $signed({3'b0, h_q});

	logic coll_hit;
	assign coll_hit = (px + XW'(BODY_HALF) > XW'(lo[0])) &&
		(px - XW'(BODY_HALF) < XW'(hi[0])) &&
		(pz + XW'(BODY_HALF) > XW'(lo[2])) &&
		(pz - XW'(BODY_HALF) < XW'(hi[2])) &&
		(yh > XW'(lo[1])) && (py < XW'(hi[1]));

	// XZ prefilter of the widened segment bounds
	logic signed [XW-1:0] sx, ex, sz, ez, vx0, vx1, vz0, vz1;
	logic pref_fail;
	assign sx  = XW'(a_q[0]);
	assign ex  = XW'(b_q[0]);
	assign sz  = XW'(a_q[2]);
	assign ez  = XW'(b_q[2]);
	assign vx0 = ((sx < ex) ? sx : ex) - XW'(VIEW_MARGIN);
	assign vx1 = ((sx > ex) ? sx : ex) + XW'(VIEW_MARGIN);
	assign vz0 = ((sz < ez) ? sz : ez) - XW'(VIEW_MARGIN);
	assign vz1 = ((sz > ez) ? sz : ez) + XW'(VIEW_MARGIN);
	assign pref_fail = (vx1 < XW'(lo[0])) || (vx0 > XW'(hi[0])) ||
		(vz1 < XW'(lo[2])) || (vz0 > XW'(hi[2]));

	// slab setup for the selected axis
	logic signed [CW-1:0] s_ax, e_ax, l_ax, h_ax;
	logic signed [NW-1:0] d_ax, t1, t2, t1n, t2n;
	logic [CW-1:0]        dmag;
	logic                 ax_active, ax_skip;

	always_comb begin
		case (cmd.axis)
			2'd1: begin
				s_ax = a_q[1]; e_ax = b_q[1]; l_ax = lo[1]; h_ax = hi[1];
			end
			2'd2: begin
				s_ax = a_q[2]; e_ax = b_q[2]; l_ax = lo[2]; h_ax = hi[2];
			end
			default: begin
				s_ax = a_q[0]; e_ax = b_q[0]; l_ax = lo[0]; h_ax = hi[0];
			end
		endcase
		d_ax = NW'(e_ax) - NW'(s_ax);
		t1   = NW'(l_ax) - NW'(s_ax);
		t2   = NW'(h_ax) - NW'(s_ax);
		if (d_ax < 0) begin
			t1n  = -t1;
			t2n  = -t2;
			dmag = CW'(-d_ax);
		end else begin
			t1n  = t1;
			t2n  = t2;
			dmag = CW'(d_ax);
		end
		ax_active = ({1'b0, dmag} > NW'(DIR_EPS));
		ax_skip   = !ax_active && !((s_ax > l_ax) && (s_ax < h_ax));
	end

	// slab interval, numerators over positive denominators
	logic signed [NW-1:0] tmin_n_q, tmax_n_q, sl_lo_q, sl_hi_q;
	logic [CW-1:0]        tmin_d_q, tmax_d_q, sl_d_q;

	// cross-multiply compare: multiply, then subtract next cycle
	logic signed [NW-1:0] an, bn;
	logic [CW-1:0]        ad, bd;
	logic signed [PW-1:0] pa_q, pb_q;
	logic signed [PW:0]   diff;

	always_comb begin
		case (cmd.sel)
			SEL_LO: begin
				an = sl_lo_q; ad = sl_d_q; bn = tmin_n_q; bd = tmin_d_q;
			end
			SEL_HI: begin
				an = sl_hi_q; ad = sl_d_q; bn = tmax_n_q; bd = tmax_d_q;
			end
			default: begin
				an = tmin_n_q; ad = tmin_d_q; bn = tmax_n_q; bd = tmax_d_q;
			end
		endcase
	end

	assign diff = (PW+1)'(pa_q) - (PW+1)'(pb_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pa_q <= an * $signed({1'b0, bd});
			pb_q <= bn * $signed({1'b0, ad});
		end
		if (cmd.lat_axis) begin
			sl_d_q <= dmag;
			if (t1n <= t2n) begin
				sl_lo_q <= t1n; sl_hi_q <= t2n;
			end else begin
				sl_lo_q <= t2n; sl_hi_q <= t1n;
			end
		end
		if (cmd.init_t) begin
			tmin_n_q <= '0;
			tmin_d_q <= CW'(1);
			tmax_n_q <= NW'(1);
			tmax_d_q <= CW'(1);
		end else if (cmd.cmp) begin
			if (cmd.sel == SEL_LO && diff > 0) begin
				tmin_n_q <= sl_lo_q; tmin_d_q <= sl_d_q;
			end
			if (cmd.sel == SEL_HI && diff < 0) begin
				tmax_n_q <= sl_hi_q; tmax_d_q <= sl_d_q;
			end
		end
	end

	// result register, strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= cmd.finish;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			answer      <= cmd.fin_ans;
			answered_op <= op_q;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.dead      = dead_q;
		sts.none      = (n_sat == '0);
		sts.last      = ((CNTW+1)'(idx_q) + 1'b1 >= (CNTW+1)'(n_sat));
		sts.kind_skip = (kind == SKIP_KIND);
		sts.pref_fail = pref_fail;
		sts.coll_hit  = coll_hit;
		sts.ax_active = ax_active;
		sts.ax_skip   = ax_skip;
		sts.blocked   = (diff <= 0) && (tmax_n_q > 0) &&
			(tmin_n_q < $signed({1'b0, tmin_d_q}));
	end

endmodule
`default_nettype wire

FILE: hw/rtl/aabb_box_table_collision_sight.sv
// Top level of the box table collision and line-of-sight unit.
//
//  channel   signals                                   transfer
//  request   start, busy, op .. body_height            start && !busy
//  result    done, answer, answered_op                 done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One request at a time. A write or unused op finishes in the dispatch state;
// a collision query reads and checks each searched box in turn, a sight
// query likewise, plus for each box that passes the kind and prefilter
// checks an axis step per axis, a multiply and compare for each slab bound
// of an axis with a moving component, and for the final interval test.
// The slab test is bound by the shared cross-multiply compare unit.
// Reset clears config and control; the box table holds nothing until written.
// The result strobe cannot be held off; config is always ready.
`default_nettype none
module aabb_box_table_collision_sight #(
	parameter int MAX_BOXES  = 256,
	parameter int COORD_BITS = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire  [1:0]        op,
	input  wire  [7:0]        entry_index,
	input  wire  [7:0]        entry_kind,
	input  wire signed [31:0] pos_a_x,
	input  wire signed [31:0] pos_a_y,
	input  wire signed [31:0] pos_a_z,
	input  wire signed [31:0] pos_b_x,
	input  wire signed [31:0] pos_b_y,
	input  wire signed [31:0] pos_b_z,
	input  wire  [30:0]       body_height,
	output logic              done,
	output logic              answer,
	output logic [1:0]        answered_op,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [1:0]        cfg_index,
	input  wire  [8:0]        cfg_data
);
	import aabb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// registers may be written any cycle
	assign cfg_ready = 1'b1;

	aabb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	aabb_dpath #(
		.MAX_BOXES  (MAX_BOXES),
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.entry_index (entry_index),
		.entry_kind  (entry_kind),
		.pos_a_x     (pos_a_x),
		.pos_a_y     (pos_a_y),
		.pos_a_z     (pos_a_z),
		.pos_b_x     (pos_b_x),
		.pos_b_y     (pos_b_y),
		.pos_b_z     (pos_b_z),
		.body_height (body_height),
		.done        (done),
		.answer      (answer),
		.answered_op (answered_op)
	);

endmodule
`default_nettype wire
